// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared widths, codes and the task-table port structures.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MAX_TASKS   = 8;
  localparam int TASK_W      = $clog2(MAX_TASKS);
  localparam int TOTAL_W     = $clog2(MAX_TASKS + 1);
  localparam int PTR_W       = 64;
  localparam int CD_W        = 16;
  localparam int PRI_W       = 8;
  localparam int FRAME_BYTES = 272;

  localparam logic [PTR_W-1:0] FRAME_ALIGN_MASK = ~PTR_W'(4'hF);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SLEEP   = 2'd1,
    OP_SET_PRI = 2'd2,
    OP_CREATE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_SWITCH = 2'd2,
    ST_IDLE      = 2'd3
  } status_t;

  // Write port of the task table; the two fields are written independently.
  typedef struct packed {
    logic                    cd_en;
    logic                    pri_en;
    logic [TASK_W-1:0]       addr;
    logic [CD_W-1:0]         cd;
    logic signed [PRI_W-1:0] pri;
  } tt_wr_t;

  // One task-table entry as seen on the read port.
  typedef struct packed {
    logic [CD_W-1:0]         cd;
    logic signed [PRI_W-1:0] pri;
  } tt_entry_t;

endpackage

// ===== rtl/pts_task_table.sv =====
// ----------------------------------------------------------------------------
// Task table
// Sleep countdown and priority per task, one write and one registered read.
// ----------------------------------------------------------------------------
module pts_task_table (
  input  logic                          clk,
  input  logic                          rst,
  input  pts_pkg::tt_wr_t               wr,
  input  logic                          rd_en,
  input  logic [pts_pkg::TASK_W-1:0]    rd_addr,
  output pts_pkg::tt_entry_t            rd_data
);

  logic [pts_pkg::CD_W-1:0]         cd_mem  [pts_pkg::MAX_TASKS];
  logic signed [pts_pkg::PRI_W-1:0] pri_mem [pts_pkg::MAX_TASKS];
  logic [pts_pkg::MAX_TASKS-1:0]    cd_vld;
  logic [pts_pkg::MAX_TASKS-1:0]    pri_vld;

  logic [pts_pkg::CD_W-1:0]         rd_cd_q;
  logic signed [pts_pkg::PRI_W-1:0] rd_pri_q;
  logic                             rd_cd_vld_q;
  logic                             rd_pri_vld_q;

  // Both fields reset to zero; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      cd_vld  <= '0;
      pri_vld <= '0;
    end else begin
      if (wr.cd_en) begin
        cd_vld[wr.addr] <= 1'b1;
      end
      if (wr.pri_en) begin
        pri_vld[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.cd_en) begin
      cd_mem[wr.addr] <= wr.cd;
    end
    if (wr.pri_en) begin
      pri_mem[wr.addr] <= wr.pri;
    end
    if (rd_en) begin
      rd_cd_q      <= cd_mem[rd_addr];
      rd_pri_q     <= pri_mem[rd_addr];
      rd_cd_vld_q  <= cd_vld[rd_addr];
      rd_pri_vld_q <= pri_vld[rd_addr];
    end
  end

  assign rd_data.cd  = rd_cd_vld_q  ? rd_cd_q  : '0;
  assign rd_data.pri = rd_pri_vld_q ? rd_pri_q : '0;

endmodule

// ===== rtl/pts_frame_store.sv =====
// ----------------------------------------------------------------------------
// Frame store
// Saved trap-frame pointer per task, one write and one registered read.
// ----------------------------------------------------------------------------
module pts_frame_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic [pts_pkg::TASK_W-1:0]    waddr,
  input  logic [pts_pkg::PTR_W-1:0]     wdata,
  input  logic                          re,
  input  logic [pts_pkg::TASK_W-1:0]    raddr,
  output logic [pts_pkg::PTR_W-1:0]     rdata
);

  logic [pts_pkg::PTR_W-1:0] mem [pts_pkg::MAX_TASKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/priority_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Priority task scheduler core
// Task table with round-robin, highest-priority selection on timer ticks.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   -------   ------------------------   ------------------------------------
//   input     in_valid / in_stall        op, stack_pointer, ticks, task_req,
//                                        priority_req
//   output    out_valid / out_stall      status, task_index, stack_pointer_out
//   config    cfg_valid / cfg_ready      cfg_data (preempt_enable)
//
// A tick with preemption enabled and at least two tasks scans the table: the
// scan reads one task-table entry per cycle through the table's single read
// port, then the FETCH state reads the chosen frame pointer and LOAD takes it.
// Every other item goes from acceptance straight to DONE.
// Reset is synchronous and leaves task 0 as the only, running task with
// preemption disabled; no clearing pass is needed.
// A stalled output holds the finished beat in the output register while the
// next input beat is already accepted and worked on.
//
module priority_task_scheduler_core (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        op,
  input  logic [pts_pkg::PTR_W-1:0]         stack_pointer,
  input  logic [pts_pkg::CD_W-1:0]          ticks,
  input  logic [2:0]                        task_req,
  input  logic signed [pts_pkg::PRI_W-1:0]  priority_req,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [2:0]                        task_index,
  output logic [pts_pkg::PTR_W-1:0]         stack_pointer_out,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data
);

  // Sequencer states. SCAN issues one table read per cycle; LAST evaluates
  // the final entry; FETCH reads the chosen pointer; LOAD captures it.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_LAST  = 6'b000100,
    S_FETCH = 6'b001000,
    S_LOAD  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic                              preempt_enable;
  logic [pts_pkg::TOTAL_W-1:0]       task_total;
  logic [pts_pkg::TASK_W-1:0]        running_task;

  // Scan bookkeeping.
  logic [pts_pkg::TASK_W-1:0]        scan_addr;
  logic [pts_pkg::TOTAL_W-1:0]       scan_left;
  logic                              proc_vld;
  logic [pts_pkg::TASK_W-1:0]        proc_addr;
  logic [pts_pkg::TASK_W-1:0]        best;
  logic signed [pts_pkg::PRI_W:0]    best_pri;

  // Result held until the output register is free.
  pts_pkg::status_t                  res_status;
  logic [pts_pkg::TASK_W-1:0]        res_index;
  logic [pts_pkg::PTR_W-1:0]         res_ptr;

  logic                              in_acc;
  pts_pkg::op_t                      op_code;
  logic                              tick_active;
  logic                              table_full;
  logic [pts_pkg::PTR_W-1:0]         frame;

  pts_pkg::tt_wr_t                   tt_wr;
  pts_pkg::tt_entry_t                tt_rd;
  logic [pts_pkg::CD_W-1:0]          cd_dec;
  logic signed [pts_pkg::PRI_W:0]    pri_ext;
  logic                              take;

  logic                              fs_we;
  logic [pts_pkg::TASK_W-1:0]        fs_waddr;
  logic [pts_pkg::PTR_W-1:0]         fs_wdata;
  logic [pts_pkg::PTR_W-1:0]         fs_rdata;

  // Next task in round-robin order among the existing tasks.
  function automatic logic [pts_pkg::TASK_W-1:0] wrap_inc(
    input logic [pts_pkg::TASK_W-1:0]  idx,
    input logic [pts_pkg::TOTAL_W-1:0] total
  );
    logic [pts_pkg::TOTAL_W-1:0] nxt;
    nxt = pts_pkg::TOTAL_W'(idx) + pts_pkg::TOTAL_W'(1);
    return (nxt == total) ? '0 : nxt[pts_pkg::TASK_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign op_code   = pts_pkg::op_t'(op);

  assign tick_active = preempt_enable && (task_total >= pts_pkg::TOTAL_W'(2));
  assign table_full  = (task_total >= pts_pkg::TOTAL_W'(pts_pkg::MAX_TASKS));
  assign frame       = (stack_pointer - pts_pkg::PTR_W'(pts_pkg::FRAME_BYTES))
                       & pts_pkg::FRAME_ALIGN_MASK;

  // Evaluation of the entry read in the previous cycle: the countdown is
  // decremented and written back, and the entry competes on its priority.
  // best_pri starts at -1 so a negative priority never wins.
  assign cd_dec  = (tt_rd.cd != '0) ? (tt_rd.cd - pts_pkg::CD_W'(1)) : '0;
  assign pri_ext = {tt_rd.pri[pts_pkg::PRI_W-1], tt_rd.pri};
  assign take    = proc_vld && (cd_dec == '0) && (pri_ext > best_pri);

  // Task-table writes. A scan writes back entry n while it reads entry n+1,
  // and the addresses within one scan are distinct, so a read never meets a
  // pending write of the same entry. Sleep and priority writes happen only
  // at acceptance, while no scan runs.
  always_comb begin
    tt_wr        = '0;
    tt_wr.addr   = running_task;
    tt_wr.cd     = ticks;
    tt_wr.pri    = priority_req;
    if (proc_vld) begin
      tt_wr.cd_en = 1'b1;
      tt_wr.addr  = proc_addr;
      tt_wr.cd    = cd_dec;
    end else if (in_acc) begin
      case (op_code)
        pts_pkg::OP_SLEEP: begin
          tt_wr.cd_en = 1'b1;
          tt_wr.addr  = running_task;
        end
        pts_pkg::OP_SET_PRI: begin
          tt_wr.pri_en = 1'b1;
          tt_wr.addr   = task_req;
        end
        default: begin
          tt_wr.cd_en  = 1'b0;
          tt_wr.pri_en = 1'b0;
        end
      endcase
    end
  end

  // Frame-store writes: a switching tick saves the running task's pointer,
  // a create stores the new task's aligned frame.
  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = running_task;
    fs_wdata = stack_pointer;
    if (in_acc) begin
      case (op_code)
        pts_pkg::OP_TICK: begin
          fs_we = tick_active;
        end
        pts_pkg::OP_CREATE: begin
          fs_we    = !table_full;
          fs_waddr = task_total[pts_pkg::TASK_W-1:0];
          fs_wdata = frame;
        end
        default: begin
          fs_we = 1'b0;
        end
      endcase
    end
  end

  pts_task_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tt_wr),
    .rd_en   (state == S_SCAN),
    .rd_addr (scan_addr),
    .rd_data (tt_rd)
  );

  pts_frame_store u_frames (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (state == S_FETCH),
    .raddr (best),
    .rdata (fs_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      preempt_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      preempt_enable <= cfg_data;
    end
  end

  // Control: sequencer, task count, running task and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      task_total   <= pts_pkg::TOTAL_W'(1);
      running_task <= '0;
      proc_vld     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      proc_vld <= (state == S_SCAN);
      // A finished beat enters the output register whenever it is free or
      // drains in the same cycle; otherwise an accepted beat empties it.
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (op_code == pts_pkg::OP_TICK && tick_active) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
            if (op_code == pts_pkg::OP_CREATE && !table_full) begin
              task_total <= task_total + pts_pkg::TOTAL_W'(1);
            end
          end
        end
        S_SCAN: begin
          if (scan_left == pts_pkg::TOTAL_W'(1)) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          running_task <= best;
          state        <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    proc_addr <= scan_addr;
    if (take) begin
      best     <= proc_addr;
      best_pri <= pri_ext;
    end
    if (state == S_SCAN) begin
      scan_addr <= wrap_inc(scan_addr, task_total);
      scan_left <= scan_left - pts_pkg::TOTAL_W'(1);
    end
    if (in_acc) begin
      scan_addr <= wrap_inc(running_task, task_total);
      scan_left <= task_total;
      best      <= running_task;
      best_pri  <= '1;
      case (op_code)
        pts_pkg::OP_TICK: begin
          res_status <= pts_pkg::ST_NO_SWITCH;
          res_index  <= running_task;
          res_ptr    <= stack_pointer;
        end
        pts_pkg::OP_CREATE: begin
          if (table_full) begin
            res_status <= pts_pkg::ST_FULL;
            res_index  <= '0;
            res_ptr    <= '0;
          end else begin
            res_status <= pts_pkg::ST_OK;
            res_index  <= task_total[pts_pkg::TASK_W-1:0];
            res_ptr    <= frame;
          end
        end
        default: begin
          res_status <= pts_pkg::ST_OK;
          res_index  <= running_task;
          res_ptr    <= '0;
        end
      endcase
    end
    if (state == S_LOAD) begin
      // With no eligible task best still names the running task, whose
      // pointer was saved when the tick was accepted.
      res_status <= best_pri[pts_pkg::PRI_W] ? pts_pkg::ST_IDLE : pts_pkg::ST_OK;
      res_index  <= best;
      res_ptr    <= fs_rdata;
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status            <= res_status;
      task_index        <= res_index;
      stack_pointer_out <= res_ptr;
    end
  end

`ifndef SYNTHESIS
  // The running task is always one of the existing tasks.
  assert property (@(posedge clk) disable iff (rst)
    pts_pkg::TOTAL_W'(running_task) < task_total)
    else $error("running task outside the task table");

  // The task count stays between one and the table size.
  assert property (@(posedge clk) disable iff (rst)
    task_total >= pts_pkg::TOTAL_W'(1) &&
    task_total <= pts_pkg::TOTAL_W'(pts_pkg::MAX_TASKS))
    else $error("task count out of range");

  // A new result appears only out of the DONE state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result beat raised outside DONE");

  // Table entries are evaluated only during a scan.
  assert property (@(posedge clk) disable iff (rst)
    proc_vld |-> (state == S_SCAN || state == S_LAST))
    else $error("entry evaluated outside a scan");
`endif

endmodule

// ===== tb/pts_schedule_checker.sv =====
// ----------------------------------------------------------------------------
// Task scheduler result checker
// Watches the request, result and preempt-enable channels of the scheduler,
// keeps its own copy of the task table, predicts the result of every
// accepted request beat and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module pts_schedule_checker (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [1:0]                        op,
  input  logic [pts_pkg::PTR_W-1:0]         stack_pointer,
  input  logic [pts_pkg::CD_W-1:0]          ticks,
  input  logic [2:0]                        task_req,
  input  logic signed [pts_pkg::PRI_W-1:0]  priority_req,

  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [1:0]                        status,
  input  logic [2:0]                        task_index,
  input  logic [pts_pkg::PTR_W-1:0]         stack_pointer_out,

  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic                              cfg_data,

  output int                                fail_count,
  output int                                pending
);

  typedef struct packed {
    pts_pkg::status_t                 status;
    logic [2:0]                       slot;
    logic [pts_pkg::PTR_W-1:0]        frame;
  } sched_result_t;

  // Shadow of the task table and the preempt-enable register.
  bit                               preempt_on;
  int                               task_count;
  logic [pts_pkg::TASK_W-1:0]       running_slot;
  logic [pts_pkg::PTR_W-1:0]        saved_frame [pts_pkg::MAX_TASKS];
  logic [pts_pkg::CD_W-1:0]         countdown   [pts_pkg::MAX_TASKS];
  logic signed [pts_pkg::PRI_W-1:0] prio        [pts_pkg::MAX_TASKS];

  sched_result_t awaited_results [$];
  int            mismatches;

  function automatic sched_result_t schedule_beat(
    pts_pkg::op_t                     code,
    logic [pts_pkg::PTR_W-1:0]        sp,
    logic [pts_pkg::CD_W-1:0]         nticks,
    logic [2:0]                       slot,
    logic signed [pts_pkg::PRI_W-1:0] pri
  );
    sched_result_t              r;
    int                         best_pri;
    int                         scan;
    logic [pts_pkg::TASK_W-1:0] best;
    bit                         found;
    logic [pts_pkg::PTR_W-1:0]  frame;
    r = '{status: pts_pkg::ST_OK, slot: running_slot, frame: '0};
    case (code)
      pts_pkg::OP_TICK: begin
        if (!preempt_on || task_count < 2) begin
          r = '{status: pts_pkg::ST_NO_SWITCH, slot: running_slot, frame: sp};
        end else begin
          saved_frame[running_slot] = sp;
          for (int i = 0; i < task_count; i++) begin
            if (countdown[i] != '0) countdown[i] = countdown[i] - 1'b1;
          end
          // Round robin: start after the running task, end on it; ties keep
          // the first candidate found, negative priorities never win.
          best     = running_slot;
          best_pri = -1;
          found    = 1'b0;
          scan     = running_slot;
          for (int i = 0; i < task_count; i++) begin
            scan = (scan + 1) % task_count;
            if (countdown[scan] == '0 && int'(prio[scan]) > best_pri) begin
              best     = pts_pkg::TASK_W'(scan);
              best_pri = int'(prio[scan]);
              found    = 1'b1;
            end
          end
          if (!found) begin
            r = '{status: pts_pkg::ST_IDLE, slot: running_slot,
                  frame: saved_frame[running_slot]};
          end else begin
            running_slot = best;
            r = '{status: pts_pkg::ST_OK, slot: best, frame: saved_frame[best]};
          end
        end
      end
      pts_pkg::OP_SLEEP: begin
        countdown[running_slot] = nticks;
      end
      pts_pkg::OP_SET_PRI: begin
        prio[slot] = pri;
      end
      pts_pkg::OP_CREATE: begin
        if (task_count >= pts_pkg::MAX_TASKS) begin
          r = '{status: pts_pkg::ST_FULL, slot: '0, frame: '0};
        end else begin
          frame = (sp - pts_pkg::PTR_W'(pts_pkg::FRAME_BYTES))
                  & ~pts_pkg::PTR_W'(4'hF);
          saved_frame[task_count] = frame;
          r = '{status: pts_pkg::ST_OK, slot: 3'(task_count), frame: frame};
          task_count++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      preempt_on   = 1'b0;
      task_count   = 1;
      running_slot = '0;
      for (int i = 0; i < pts_pkg::MAX_TASKS; i++) begin
        saved_frame[i] = '0;
        countdown[i]   = '0;
        prio[i]        = '0;
      end
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) preempt_on = cfg_data;

      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: status %0d task %0d ptr %h",
                     status, task_index, stack_pointer_out);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status || task_index !== want.slot ||
              stack_pointer_out !== want.frame) begin
            mismatches++;
            if (mismatches <= 10)
              $display(
                "mismatch: expected status %0d task %0d ptr %h, got status %0d task %0d ptr %h",
                want.status, want.slot, want.frame,
                status, task_index, stack_pointer_out);
          end
        end
      end

      if (in_valid && !in_stall)
        awaited_results.push_back(schedule_beat(pts_pkg::op_t'(op), stack_pointer,
                                                ticks, task_req, priority_req));
    end
    fail_count <= mismatches;
    pending    <= awaited_results.size();
  end

endmodule

// ===== tb/priority_task_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Drives directed and random scheduler requests with random gaps and output
// stalls, toggles preemption between phases, and lets the checker beside the
// block predict and compare every result beat.
// ----------------------------------------------------------------------------
module priority_task_scheduler_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  // The tail wait outlasts a switching tick with a full table, with room to spare.
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 250;

  logic                             clk = 1'b0;
  logic                             rst;

  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       op;
  logic [pts_pkg::PTR_W-1:0]        stack_pointer;
  logic [pts_pkg::CD_W-1:0]         ticks;
  logic [2:0]                       task_req;
  logic signed [pts_pkg::PRI_W-1:0] priority_req;

  logic                             out_valid;
  logic                             out_stall;
  logic [1:0]                       status;
  logic [2:0]                       task_index;
  logic [pts_pkg::PTR_W-1:0]        stack_pointer_out;

  logic                             cfg_valid;
  logic                             cfg_ready;
  logic                             cfg_data;

  int                               fail_count;
  int                               pending;
  int                               cycle_count = 0;

  // When calm is set neither side idles; hold_request asks the stall process
  // for one long hold-off of the result channel.
  bit                               calm = 1'b0;
  bit                               hold_request = 1'b0;

  priority_task_scheduler_core dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .op                (op),
    .stack_pointer     (stack_pointer),
    .ticks             (ticks),
    .task_req          (task_req),
    .priority_req      (priority_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .task_index        (task_index),
    .stack_pointer_out (stack_pointer_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  pts_schedule_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .op                (op),
    .stack_pointer     (stack_pointer),
    .ticks             (ticks),
    .task_req          (task_req),
    .priority_req      (priority_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .task_index        (task_index),
    .stack_pointer_out (stack_pointer_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Gap before the next request beat: mostly back to back or short, now and
  // then a long pause.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result-side stall pattern. Every pass drives out_stall exactly once and
  // then waits for a clock edge, so no step sees two assignments.
  initial begin
    bit stall_level;
    int span;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_level  = 1'b1;
        span         = HOLD_CYCLES;
      end else if (calm) begin
        stall_level = 1'b0;
        span        = 1;
      end else if ($urandom_range(0, 2) != 0) begin
        stall_level = 1'b0;
        span        = $urandom_range(1, 10);
      end else begin
        stall_level = 1'b1;
        span        = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
      end
      out_stall <= stall_level;
      repeat (span) @(posedge clk);
    end
  end

  // Offers one request beat and returns at the edge that accepted it, with
  // in_valid still high so that a following back-to-back beat needs no
  // second assignment in the same step.
  task automatic offer_request(
    pts_pkg::op_t                     code,
    logic [pts_pkg::PTR_W-1:0]        sp,
    logic [pts_pkg::CD_W-1:0]         nticks,
    logic [2:0]                       slot,
    logic signed [pts_pkg::PRI_W-1:0] pri
  );
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= code;
    stack_pointer <= sp;
    ticks         <= nticks;
    task_req      <= slot;
    priority_req  <= pri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random request. Sleeps are mostly short and priorities mostly near zero
  // so that ties, negative priorities and all-blocked ticks keep turning up.
  task automatic offer_random_request();
    int                               pick;
    pts_pkg::op_t                     code;
    logic [pts_pkg::CD_W-1:0]         nticks;
    logic signed [pts_pkg::PRI_W-1:0] pri;
    pick = $urandom_range(0, 99);
    if (pick < 45)      code = pts_pkg::OP_TICK;
    else if (pick < 65) code = pts_pkg::OP_SLEEP;
    else if (pick < 90) code = pts_pkg::OP_SET_PRI;
    else                code = pts_pkg::OP_CREATE;
    nticks = ($urandom_range(0, 99) == 0) ? pts_pkg::CD_W'($urandom)
                                          : pts_pkg::CD_W'($urandom_range(0, 6));
    pri    = ($urandom_range(0, 9) == 0) ? pts_pkg::PRI_W'($urandom)
                                         : pts_pkg::PRI_W'($urandom_range(0, 6) - 2);
    offer_request(code, {$urandom, $urandom}, nticks, 3'($urandom_range(0, 7)), pri);
  endtask

  // Stops offering and waits until every predicted result has come back,
  // then lets the block settle so that it is quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_preempt(bit enable);
    cfg_valid <= 1'b1;
    cfg_data  <= enable;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    op            <= pts_pkg::OP_TICK;
    stack_pointer <= '0;
    ticks         <= '0;
    task_req      <= '0;
    priority_req  <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Preemption is off after reset: ticks must hand the pointer straight
    // back, first with the lone main task, then with two tasks.
    offer_request(pts_pkg::OP_TICK, '1, '0, '0, '0);
    offer_request(pts_pkg::OP_CREATE, '0, '0, '0, '0);   // frame wraps below zero
    offer_request(pts_pkg::OP_TICK, {$urandom, $urandom}, '0, '0, '0);
    drain_results();
    write_preempt(1'b1);

    // Switching, creates at the pointer extremes and priority writes at the
    // field extremes, including a slot that does not exist yet.
    offer_request(pts_pkg::OP_TICK, 64'h1000, '0, '0, '0);
    offer_request(pts_pkg::OP_CREATE, '1, '0, '0, '0);
    // The frame lands on zero.
    offer_request(pts_pkg::OP_CREATE, pts_pkg::PTR_W'(pts_pkg::FRAME_BYTES), '0, '0, '0);
    offer_request(pts_pkg::OP_SET_PRI, '0, '0, 3'd7, 8'sd127);
    offer_request(pts_pkg::OP_SET_PRI, '0, '0, 3'd2, -8'sd128);
    // Longest sleep, then overwritten by a zero sleep before any tick.
    offer_request(pts_pkg::OP_SLEEP, '0, '1, '0, '0);
    offer_request(pts_pkg::OP_SLEEP, '0, '0, '0, '0);
    // Every ready task negative and the running one asleep: idle ticks.
    offer_request(pts_pkg::OP_SET_PRI, '0, '0, 3'd0, -8'sd1);
    offer_request(pts_pkg::OP_SET_PRI, '0, '0, 3'd3, -8'sd5);
    offer_request(pts_pkg::OP_SLEEP, '0, 16'd3, '0, '0);
    offer_request(pts_pkg::OP_TICK, 64'hDEAD_BEEF_0000_1230, '0, '0, '0);
    offer_request(pts_pkg::OP_TICK, 64'h0000_0000_0000_0008, '0, '0, '0);
    // Back to switching, with equal priorities resolved by round-robin order.
    offer_request(pts_pkg::OP_SET_PRI, '0, '0, 3'd3, 8'sd5);
    offer_request(pts_pkg::OP_TICK, 64'h2000, '0, '0, '0);
    offer_request(pts_pkg::OP_SET_PRI, '0, '0, 3'd0, 8'sd5);
    offer_request(pts_pkg::OP_TICK, 64'h3000, '0, '0, '0);
    offer_request(pts_pkg::OP_TICK, '0, '0, '0, '0);

    // Back-pressure: the result side holds off for a long stretch while
    // request beats keep coming, so the block fills and stalls its input.
    hold_request = 1'b1;
    repeat (30) begin
      if ($urandom_range(0, 1) != 0) offer_request(pts_pkg::OP_TICK, {$urandom, $urandom},
                                                   '0, '0, '0);
      else offer_random_request();
    end
    repeat (120) offer_random_request();
    drain_results();

    // Preemption off again with a grown table.
    write_preempt(1'b0);
    repeat (60) offer_random_request();
    drain_results();

    // Preemption back on; the first stretch runs with no idling on either
    // side, the rest with random gaps again.
    write_preempt(1'b1);
    calm = 1'b1;
    repeat (60) offer_random_request();
    calm = 1'b0;
    repeat (130) offer_random_request();

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
